// ===== rtl/csse_pkg.sv =====
// Shared types, register indexes and helpers for the character-set scanner.
package csse_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PATTERN_CHARS  = 3'd0,
        REG_PATTERN_COUNT  = 3'd1,
        REG_CASE_SENSITIVE = 3'd2,
        REG_FIND_MODE      = 3'd3,
        REG_ESCAPE_CHAR    = 3'd4
    } cfg_index_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned INDEX_W    = 17;

    localparam logic [CHAR_W-1:0] NO_ESCAPE = 8'h00;

    // Current configuration, handed to the match unit as one group
    typedef struct packed {
        logic [63:0]       pattern_chars;
        logic [3:0]        pattern_count;
        logic              case_sensitive;
        logic              find_mode;
        logic [CHAR_W-1:0] escape_char;
    } cfg_t;

    // Classification of one byte
    typedef struct packed {
        logic is_escape;
        logic hit;
    } match_t;

    // Fold a-z to A-Z when folding is on.
    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] b,
                                                    input logic fold_on);
        if (fold_on && b >= 8'h61 && b <= 8'h7A) begin
            return b - 8'h20;
        end
        return b;
    endfunction

endpackage

// ===== rtl/csse_match.sv =====
// Byte classifier: case folding, escape detection and parallel set compare.
module csse_match import csse_pkg::*; #(
    parameter int PATTERN_SLOTS = 8
) (
    input  cfg_t              cfg,
    input  logic [CHAR_W-1:0] char_in,
    output match_t            result
);

    localparam logic [3:0] SLOTS = 4'(PATTERN_SLOTS);

    logic [CHAR_W-1:0] folded;
    logic [3:0]        used_slots;
    logic              in_set;

    // Fold the byte and clamp the slot count to the comparators present.
    always_comb begin
        folded     = fold_byte(char_in, !cfg.case_sensitive);
        used_slots = (cfg.pattern_count > SLOTS) ? SLOTS : cfg.pattern_count;
    end

    // One comparator per slot, all in parallel.
    always_comb begin
        in_set = 1'b0;
        for (int k = 0; k < PATTERN_SLOTS; k++) begin
            if (4'(k) < used_slots &&
                fold_byte(cfg.pattern_chars[k*CHAR_W +: CHAR_W], !cfg.case_sensitive)
                    == folded) begin
                in_set = 1'b1;
            end
        end
    end

    // An empty set matches nothing in either mode.
    always_comb begin
        result.is_escape = (cfg.escape_char != NO_ESCAPE) && (folded == cfg.escape_char);
        if (used_slots == 4'd0) begin
            result.hit = 1'b0;
        end else begin
            result.hit = cfg.find_mode ? in_set : !in_set;
        end
    end

endmodule

// ===== rtl/char_set_scanner_with_escape.sv =====
// Top level of the character-set scanner with escape handling.
// A result beat passes from the input register through the compare to the result register.
// Throughput: one byte per cycle, set by the single-pass compare; a byte that gives a result
// waits while the result register is full, which takes a new beat while m_tready is high.
// Reset: aresetn is synchronous and active low; it empties both stages, clears the scan
// state and loads the register defaults (empty set, case-sensitive, find mode, no escape).
module char_set_scanner_with_escape import csse_pkg::*; #(
    parameter int              PATTERN_SLOTS = 8,
    parameter longint unsigned MAX_LEN       = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_in
    input  logic                  s_tlast,   // is_last
    // Result stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] position
    output logic                  m_tuser    // [0] found
);

    localparam longint unsigned INDEX_LIMIT = (MAX_LEN < 64'd65536) ? MAX_LEN : 64'd65536;
    localparam logic [INDEX_W-1:0] IDX_LIM = INDEX_W'(INDEX_LIMIT);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_last_reg;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               skip_reg, skip_next;
    logic               rep_reg, rep_next;
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [POS_W-1:0]   m_pos_reg;

    match_t             match;
    logic               hit;
    logic               emit;
    logic               out_free;
    logic               advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_chars  <= '0;
            cfg_reg.pattern_count  <= '0;
            cfg_reg.case_sensitive <= 1'b1;
            cfg_reg.find_mode      <= 1'b1;
            cfg_reg.escape_char    <= NO_ESCAPE;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_idx))
                REG_PATTERN_CHARS:  cfg_reg.pattern_chars  <= cfg_wdata;
                REG_PATTERN_COUNT:  cfg_reg.pattern_count  <= cfg_wdata[3:0];
                REG_CASE_SENSITIVE: cfg_reg.case_sensitive <= cfg_wdata[0];
                REG_FIND_MODE:      cfg_reg.find_mode      <= cfg_wdata[0];
                REG_ESCAPE_CHAR:    cfg_reg.escape_char    <= cfg_wdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    csse_match #(
        .PATTERN_SLOTS(PATTERN_SLOTS)
    ) u_match (
        .cfg     (cfg_reg),
        .char_in (in_char_reg),
        .result  (match)
    );

    // Scan state update for the byte in the input register.
    always_comb begin
        hit       = 1'b0;
        emit      = 1'b0;
        skip_next = skip_reg;
        rep_next  = rep_reg;
        if (!rep_reg) begin
            if (skip_reg) begin
                skip_next = 1'b0;
            end else if (match.is_escape) begin
                skip_next = 1'b1;
            end else if (idx_reg < IDX_LIM && match.hit) begin
                hit = 1'b1;
            end
            if (hit) begin
                emit     = 1'b1;
                rep_next = 1'b1;
            end else if (in_last_reg) begin
                emit = 1'b1;
            end
        end
        idx_next = (idx_reg < IDX_LIM) ? idx_reg + 1'b1 : idx_reg;
        // The last byte of a string starts the next one afresh.
        if (in_last_reg) begin
            idx_next  = '0;
            skip_next = 1'b0;
            rep_next  = 1'b0;
        end
    end

    // Handshake between the two stages
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            skip_reg <= 1'b0;
            rep_reg  <= 1'b0;
        end else if (advance) begin
            idx_reg  <= idx_next;
            skip_reg <= skip_next;
            rep_reg  <= rep_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_found_reg <= hit;
            m_pos_reg   <= hit ? idx_reg[POS_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pos_reg;
    assign m_tuser  = m_found_reg;

endmodule

// ===== rtl/csse_checker.sv =====
// Port-level assertions for the scanner, bound to the top level.
module csse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A not-found result always carries position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("not-found result with nonzero position");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // Reset empties the input register, so a byte can be taken at once.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready straight after reset");

endmodule

bind char_set_scanner_with_escape csse_checker u_csse_checker (.*);

// ===== tb/sv/csse_scan_checker.sv =====
// Checker for the character-set scanner: tracks configuration, predicts results and compares them.
module csse_scan_checker import csse_pkg::*; #(
    parameter int              PATTERN_SLOTS = 8,
    parameter longint unsigned MAX_LEN       = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tuser,
    output int unsigned           error_count,
    output int unsigned           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Bytes at this index or beyond are never reported.
    localparam longint unsigned INDEX_LIMIT = (MAX_LEN < 65536) ? MAX_LEN : 65536;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } scan_result_t;

    scan_result_t       expected_results[$];
    cfg_t               cfg;
    logic [INDEX_W-1:0] byte_pos;
    logic               skip_pending;
    logic               string_done;
    int unsigned        faults  = 0;
    int unsigned        waiting = 0;

    assign error_count   = faults;
    assign pending_count = waiting;

    // Upper-case a-z when folding is enabled.
    function automatic logic [7:0] upcase(input logic [7:0] b, input logic on);
        if (on && b >= 8'h61 && b <= 8'h7A) begin
            return b - 8'h20;
        end
        return b;
    endfunction

    // Decide whether a folded byte stops the scan under the current mode.
    function automatic logic stops_scan(input logic [7:0] f);
        int   n;
        int   k;
        logic member;
        n = (cfg.pattern_count > PATTERN_SLOTS) ? PATTERN_SLOTS : int'(cfg.pattern_count);
        if (n == 0) begin
            return 1'b0;
        end
        member = 1'b0;
        for (k = 0; k < n; k++) begin
            if (upcase(cfg.pattern_chars[k*8 +: 8], !cfg.case_sensitive) == f) begin
                member = 1'b1;
            end
        end
        return cfg.find_mode ? member : !member;
    endfunction

    // Advance the scan by one byte and queue the result it gives, if any.
    function automatic void scan_byte(input logic [7:0] c, input logic last);
        logic [7:0] f;
        logic       hit;
        hit = 1'b0;
        if (!string_done) begin
            if (skip_pending) begin
                skip_pending = 1'b0;
            end else begin
                f = upcase(c, !cfg.case_sensitive);
                if (cfg.escape_char != NO_ESCAPE && f == cfg.escape_char) begin
                    skip_pending = 1'b1;
                end else if (byte_pos < INDEX_LIMIT && stops_scan(f)) begin
                    hit = 1'b1;
                end
            end
            if (hit) begin
                expected_results.push_back('{found: 1'b1, position: byte_pos[POS_W-1:0]});
                string_done = 1'b1;
            end else if (last) begin
                expected_results.push_back('{found: 1'b0, position: '0});
            end
        end
        if (byte_pos < INDEX_LIMIT) begin
            byte_pos = byte_pos + 1'b1;
        end
        if (last) begin
            byte_pos     = '0;
            skip_pending = 1'b0;
            string_done  = 1'b0;
        end
    endfunction

    // All channels are sampled at the rising edge, before any of this edge's updates land.
    always @(posedge aclk) begin
        scan_result_t got;
        scan_result_t want;
        if (!aresetn) begin
            cfg.pattern_chars  = '0;
            cfg.pattern_count  = '0;
            cfg.case_sensitive = 1'b1;
            cfg.find_mode      = 1'b1;
            cfg.escape_char    = NO_ESCAPE;
            byte_pos           = '0;
            skip_pending       = 1'b0;
            string_done        = 1'b0;
            expected_results.delete();
        end else begin
            // Result beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.found    = m_tuser;
                got.position = m_tdata;
                if (expected_results.size() == 0) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("%0t: unexpected result beat found=%b position=%0d",
                                 $realtime, got.found, got.position);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.position !== want.position) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("%0t: result mismatch: expected found=%b position=%0d, got found=%b position=%0d",
                                     $realtime, want.found, want.position, got.found, got.position);
                        end
                    end
                end
            end
            // Byte beat into the predictor
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
            end
            // Register writes, masked to each register's width
            if (cfg_we) begin
                case (cfg_idx)
                    REG_PATTERN_CHARS:  cfg.pattern_chars  = cfg_wdata;
                    REG_PATTERN_COUNT:  cfg.pattern_count  = cfg_wdata[3:0];
                    REG_CASE_SENSITIVE: cfg.case_sensitive = cfg_wdata[0];
                    REG_FIND_MODE:      cfg.find_mode      = cfg_wdata[0];
                    REG_ESCAPE_CHAR:    cfg.escape_char    = cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        waiting = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_char_set_scanner_with_escape.sv =====
// Testbench top for the character-set scanner: clock, reset, stimulus and the verdict.
module tb_char_set_scanner_with_escape;
    import csse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // An index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int                   RANDOM_BYTES = 800;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    int unsigned           error_count;
    int unsigned           pending_count;

    // Sender pacing and per-phase stimulus state
    int          burst_left    = 0;
    bit          sender_steady = 1'b0;
    int unsigned bytes_sent    = 0;
    logic [7:0]  text_buf[$];
    logic [63:0] ph_chars;
    logic [7:0]  ph_esc;

    // Receiver stall pattern state
    int   rx_left  = 0;
    int   rx_mode  = 0;
    int   rx_run   = 0;
    int   rx_tick  = 0;
    logic rx_level = 1'b1;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    char_set_scanner_with_escape dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    csse_scan_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Receiver: picks one of four stall patterns at random for each run of cycles.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_tick % 4 == 0);
            default: begin
                if (rx_run == 0) begin
                    rx_run   = $urandom_range(1, 12);
                    rx_level = ~rx_level;
                end
                rx_run--;
                m_tready <= rx_level;
            end
        endcase
    end

    // Present one byte beat and hold it until it is taken; gaps fall between bursts.
    task automatic send_beat(input logic [7:0] c, input logic last);
        int gap;
        if (!sender_steady && burst_left <= 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  <= c;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Send the buffered string, the last byte flagged with tlast.
    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            send_beat(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    // Let every expected result arrive before the next write.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Write all registers; unused upper bits carry junk, which the block must drop.
    task automatic set_config(input logic [63:0] chars, input logic [3:0] count,
                              input logic cs, input logic fm, input logic [7:0] esc);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_PATTERN_CHARS, chars);
        write_reg(REG_PATTERN_COUNT, {junk[63:4], count});
        write_reg(REG_CASE_SENSITIVE, {junk[63:1], cs});
        write_reg(REG_FIND_MODE, {junk[63:1], fm});
        write_reg(REG_ESCAPE_CHAR, {junk[63:8], esc});
        write_reg(REG_UNMAPPED, junk);
        cfg_we <= 1'b0;
        ph_chars = chars;
        ph_esc   = esc;
    endtask

    // Pick a byte that is likely to interact with the set or the escape.
    function automatic logic [7:0] pick_byte();
        logic [7:0] slot;
        slot = ph_chars[$urandom_range(0, 7)*8 +: 8];
        case ($urandom_range(0, 9))
            0, 1, 2: return slot;
            3:       return slot ^ 8'h20;
            4:       return (ph_esc != NO_ESCAPE) ? ph_esc : slot;
            5:       return ph_esc ^ 8'h20;
            6:       return 8'(8'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) * 8'h20));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One random phase: fresh configuration, then strings of mostly short length.
    task automatic random_phase(input int phase, input int n_bytes);
        logic [63:0] chars;
        logic [3:0]  count;
        logic [7:0]  esc;
        int          k;
        int          len;
        int          sent;
        case (phase % 5)
            0:       chars = '1;
            1:       chars = '0;
            default: begin
                for (k = 0; k < 8; k++) begin
                    chars[k*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'(8'h41 + $urandom_range(0, 25)
                                           + $urandom_range(0, 1) * 8'h20);
                end
            end
        endcase
        count = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
        case ($urandom_range(0, 5))
            0, 1:    esc = NO_ESCAPE;
            2:       esc = 8'hFF;
            3:       esc = chars[$urandom_range(0, 7)*8 +: 8];
            default: esc = 8'($urandom_range(1, 255));
        endcase
        set_config(chars, count, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), esc);
        sender_steady = ($urandom_range(0, 3) == 0);
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            text_buf.delete();
            for (k = 0; k < len; k++) begin
                text_buf.push_back(pick_byte());
            end
            send_text();
            sent += len;
        end
        bytes_sent += sent;
        drain();
    endtask

    // Stimulus and verdict
    initial begin
        int phase;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_PATTERN_CHARS;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b1;
        ph_chars  = '0;
        ph_esc    = NO_ESCAPE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: the empty set matches nothing, and a zero byte is ordinary.
        text_buf = '{"a", "b"};
        send_text();
        text_buf = '{8'h00, 8'hFF};
        send_text();
        drain();

        // Find mode, exact compare, backslash escape; set holds a, Z, 0x00 and 0xFF.
        set_config(64'h00000000_FF005A61, 4'd4, 1'b1, 1'b1, 8'h5C);
        text_buf = '{8'h00};
        send_text();
        text_buf = '{"x", 8'h5C, "a", "Z"};
        send_text();
        text_buf = '{"b", "a", "Z", "q"};
        send_text();
        // An escape on the last byte must not carry into the next string.
        text_buf = '{"x", 8'h5C};
        send_text();
        text_buf = '{"a"};
        send_text();
        drain();

        // Exclusion mode with folding and an oversized count; Q escapes after folding.
        set_config(64'h68676665_64636261, 4'd12, 1'b0, 1'b0, "Q");
        text_buf = '{"A", "b", "q", "z", "C"};
        send_text();
        text_buf = '{"H", 8'hFF};
        send_text();
        drain();

        // All-ones set and escape, exclusion mode.
        set_config('1, 4'd8, 1'b1, 1'b0, 8'hFF);
        text_buf = '{8'hFF, 8'h01, 8'hFF};
        send_text();
        text_buf = '{8'h7F};
        send_text();
        drain();

        // A lower-case escape is never seen once the byte is folded.
        set_config(64'h61, 4'd1, 1'b0, 1'b1, "q");
        text_buf = '{"q", "a"};
        send_text();
        drain();

        // Random phases until enough bytes have gone in
        phase = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            random_phase(phase, $urandom_range(30, 70));
            phase++;
        end

        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb_char_set_scanner_with_escape OK");
        end else begin
            $display("tb_char_set_scanner_with_escape NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb_char_set_scanner_with_escape NOT OK");
        $finish;
    end

endmodule
